FILE: rtl/core/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants and controller/datapath interface types for the shear
// sort matrix block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int VALUE_W     = 32;
    localparam int SIDE_W      = 4;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_we;    // write the incoming word to the store
        logic              sort_we;    // write a line buffer lane back to the store
        logic              rd_en;      // read the store into the read register
        logic              line_rd;    // the read feeds the line buffer
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  lane_sel;   // lane written back
        logic              line_clr;   // empty the line buffer
        logic              desc;       // descending order for the current line
        logic              out_load;   // move the read register to the output
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic              out_last;
    } ssm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
    } ssm_stat_t;

endpackage

FILE: rtl/core/shear_sort_matrix.sv
// ----------------------------------------------------------------------------
// shear_sort_matrix
// Shear sort of an n-by-n matrix of signed 32-bit words, n from 1 to 8.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on element_value with element_valid/element_stall in
//   row-major order, one word a cycle while loading. write_enable with
//   write_data sets the side n (0 acts as 1, above 8 acts as 8) and drops
//   any partial load; write it only while the block is idle.
//   After the n*n-th word the block stalls its input and runs ceil(log2 n)
//   phases, each sorting every row (even rows ascending, odd descending)
//   then every column ascending. A line is read from the store word by
//   word into the insertion buffer (ST_READ), left to settle (ST_INSERT)
//   and written back lane by lane (ST_WRITE), all through the single-port store.
//   Results leave on sorted_value, row_index, col_index and last_of_run with
//   result_valid/result_stall, row-major; each word is read from the
//   store (ST_OUT_READ), then moved to the output register (ST_OUT_LOAD)
//   only when that register is free. A stalled result word holds; the
//   sequencer waits on it. Input is taken again as soon as the final word
//   sits in the output register. Reset empties the load and sets n to 8.
// ----------------------------------------------------------------------------
module shear_sort_matrix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_enable,
    input  logic [3:0]  write_data,
    input  logic        element_valid,
    output logic        element_stall,
    input  logic [31:0] element_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] sorted_value,
    output logic [2:0]  row_index,
    output logic [2:0]  col_index,
    output logic        last_of_run
);
    import ssm_pkg::*;

    ssm_cmd_t  cmd;
    ssm_stat_t stat;

    ssm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .write_enable  (write_enable),
        .write_data    (write_data),
        .stat          (stat),
        .cmd           (cmd)
    );

    ssm_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .element_value (element_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sorted_value  (sorted_value),
        .row_index     (row_index),
        .col_index     (col_index),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: rtl/core/ssm_datapath.sv
// ----------------------------------------------------------------------------
// ssm_datapath
// Matrix store, insertion line buffer and output register. Lines are read
// from the store one word a cycle and inserted in order into the buffer,
// then written back lane by lane.
// ----------------------------------------------------------------------------
module ssm_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssm_pkg::ssm_cmd_t cmd,
    output ssm_pkg::ssm_stat_t stat,
    input  logic [31:0]       element_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [31:0]       sorted_value,
    output logic [2:0]        row_index,
    output logic [2:0]        col_index,
    output logic              last_of_run
);
    import ssm_pkg::*;

    value_t            store_mem [STORE_DEPTH];
    value_t            rd_data_reg;
    logic              ins_pending_reg;
    value_t            lane_reg  [MAX_SIDE];
    value_t            lane_next [MAX_SIDE];
    logic [SIDE_W-1:0] lane_cnt_reg;
    logic [SIDE_W-1:0] lane_cnt_next;
    logic [MAX_SIDE-1:0] keep;
    value_t            wr_data;

    value_t            sorted_value_reg;
    logic [IDX_W-1:0]  row_index_reg;
    logic [IDX_W-1:0]  col_index_reg;
    logic              last_of_run_reg;
    logic              result_valid_reg;

    assign wr_data = cmd.load_we ? value_t'(element_value) : lane_reg[cmd.lane_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.load_we || cmd.sort_we)
        begin
            store_mem[cmd.addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[cmd.addr];
        end
    end

    // Insertion: lanes holding values that the new word does not precede
    // stay put, the first other lane takes the word, the rest shift up.
    always_comb
    begin
        for (int i = 0; i < MAX_SIDE; i++)
        begin
            keep[i] = (SIDE_W'(i) < lane_cnt_reg) &&
                      !(cmd.desc ? (rd_data_reg > lane_reg[i]) : (rd_data_reg < lane_reg[i]));
        end
        lane_next[0] = keep[0] ? lane_reg[0] : rd_data_reg;
        for (int i = 1; i < MAX_SIDE; i++)
        begin
            if (keep[i])
                lane_next[i] = lane_reg[i];
            else if (keep[i-1])
                lane_next[i] = rd_data_reg;
            else
                lane_next[i] = lane_reg[i-1];
        end
        lane_cnt_next = lane_cnt_reg;
        if (cmd.line_clr)
            lane_cnt_next = '0;
        else if (ins_pending_reg)
            lane_cnt_next = lane_cnt_reg + SIDE_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ins_pending_reg)
        begin
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                lane_reg[i] <= lane_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_pending_reg  <= 1'b0;
            lane_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // only line reads feed the buffer; output reads do not
            ins_pending_reg <= cmd.line_rd;
            lane_cnt_reg <= lane_cnt_next;
            if (cmd.out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sorted_value_reg <= rd_data_reg;
            row_index_reg    <= cmd.out_row;
            col_index_reg    <= cmd.out_col;
            last_of_run_reg  <= cmd.out_last;
        end
    end

    assign stat.out_free = !result_valid_reg || !result_stall;
    assign result_valid  = result_valid_reg;
    assign sorted_value  = sorted_value_reg;
    assign row_index     = row_index_reg;
    assign col_index     = col_index_reg;
    assign last_of_run   = last_of_run_reg;

endmodule

FILE: rtl/core/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer for load, shear sort phases and row-major read-out. Holds the
// side register and the load count.
// ----------------------------------------------------------------------------
module ssm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               element_valid,
    output logic               element_stall,
    input  logic               write_enable,
    input  logic [3:0]         write_data,
    input  ssm_pkg::ssm_stat_t stat,
    output ssm_pkg::ssm_cmd_t  cmd
);
    import ssm_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_INSERT,
        ST_WRITE,
        ST_OUT_READ,
        ST_OUT_LOAD
    } state_t;

    state_t             state_reg,      state_next;
    logic [SIDE_W-1:0]  side_reg,       side_next;
    logic [COUNT_W-1:0] load_count_reg, load_count_next;
    logic [IDX_W-1:0]   line_reg,       line_next;
    logic [IDX_W-1:0]   idx_reg,        idx_next;
    logic               col_pass_reg,   col_pass_next;
    logic [SIDE_W-1:0]  span_reg,       span_next;

    logic [SIDE_W-1:0]  side_eff;
    logic [IDX_W-1:0]   side_last;
    logic [COUNT_W-1:0] total_m1;
    logic               idx_end;
    logic               line_end;
    logic [IDX_W-1:0]   row_sel;
    logic [IDX_W-1:0]   col_sel;
    logic [COUNT_W-1:0] line_addr;
    logic               accept;

    always_comb
    begin
        if (side_reg == '0)
            side_eff = SIDE_W'(1);
        else if (side_reg > SIDE_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = side_reg;
    end

    assign side_last = IDX_W'(side_eff - SIDE_W'(1));
    assign total_m1  = COUNT_W'(side_eff) * COUNT_W'(side_eff) - COUNT_W'(1);
    assign idx_end   = (idx_reg == side_last);
    assign line_end  = (line_reg == side_last);
    assign row_sel   = col_pass_reg ? idx_reg : line_reg;
    assign col_sel   = col_pass_reg ? line_reg : idx_reg;
    assign line_addr = COUNT_W'(row_sel) * COUNT_W'(side_eff) + COUNT_W'(col_sel);
    assign accept    = element_valid && (state_reg == ST_LOAD);

    assign element_stall = (state_reg != ST_LOAD);

    always_comb
    begin
        cmd          = '0;
        cmd.addr     = (state_reg == ST_LOAD) ? load_count_reg[ADDR_W-1:0]
                                              : line_addr[ADDR_W-1:0];
        cmd.lane_sel = idx_reg;
        cmd.desc     = !col_pass_reg && line_reg[0];
        cmd.out_row  = line_reg;
        cmd.out_col  = idx_reg;
        cmd.out_last = line_end && idx_end;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_we = accept;
            end
            ST_READ:
            begin
                cmd.rd_en    = 1'b1;
                cmd.line_rd  = 1'b1;
                cmd.line_clr = (idx_reg == '0);
            end
            ST_WRITE:
            begin
                cmd.sort_we = 1'b1;
            end
            ST_OUT_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        side_next       = side_reg;
        load_count_next = load_count_reg;
        line_next       = line_reg;
        idx_next        = idx_reg;
        col_pass_next   = col_pass_reg;
        span_next       = span_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (load_count_reg == total_m1)
                    begin
                        load_count_next = '0;
                        line_next       = '0;
                        idx_next        = '0;
                        col_pass_next   = 1'b0;
                        span_next       = SIDE_W'(1);
                        state_next      = (side_eff == SIDE_W'(1)) ? ST_OUT_READ : ST_READ;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                if (idx_end)
                begin
                    idx_next   = '0;
                    state_next = ST_INSERT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (idx_end)
                begin
                    idx_next   = '0;
                    state_next = ST_READ;
                    if (line_end)
                    begin
                        line_next = '0;
                        if (!col_pass_reg)
                        begin
                            col_pass_next = 1'b1;
                        end
                        else
                        begin
                            // phase done: double the span, stop once it reaches or passes n
                            col_pass_next = 1'b0;
                            span_next     = SIDE_W'({span_reg, 1'b0});
                            if ({span_reg, 1'b0} >= {1'b0, side_eff})
                                state_next = ST_OUT_READ;
                        end
                    end
                    else
                    begin
                        line_next = line_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_OUT_READ:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                if (stat.out_free)
                begin
                    if (idx_end)
                    begin
                        idx_next = '0;
                        if (line_end)
                        begin
                            line_next  = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            line_next  = line_reg + IDX_W'(1);
                            state_next = ST_OUT_READ;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_OUT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        // side change drops any partial load
        if (write_enable)
        begin
            side_next       = write_data;
            load_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            side_reg       <= SIDE_W'(MAX_SIDE);
            load_count_reg <= '0;
            line_reg       <= '0;
            idx_reg        <= '0;
            col_pass_reg   <= 1'b0;
            span_reg       <= SIDE_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            side_reg       <= side_next;
            load_count_reg <= load_count_next;
            line_reg       <= line_next;
            idx_reg        <= idx_next;
            col_pass_reg   <= col_pass_next;
            span_reg       <= span_next;
        end
    end

endmodule
